// ===== hdl/blit_rect_clipper_unit_assert.svh =====
// Assertion helpers for the clipper RTL
`ifndef BLIT_RECT_CLIPPER_UNIT_ASSERT_SVH
`define BLIT_RECT_CLIPPER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BRCU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("blit clipper check failed");
`define BRCU_ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("blit clipper forbidden condition");
`else
`define BRCU_ASSERT_IMP(lbl, ante, cons)
`define BRCU_ASSERT_NEVER(lbl, expr)
`endif
`endif

// ===== hdl/blitclp_pkg.sv =====
`default_nettype none
package blitclp_pkg;

	localparam int COORD_BITS_DEF  = 16;
	localparam int VIEW_WIDTH_RST  = 640;
	localparam int VIEW_HEIGHT_RST = 480;
	localparam int CFG_IDX_W       = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VIEW_LEFT   = 2'd0,
		REG_VIEW_TOP    = 2'd1,
		REG_VIEW_WIDTH  = 2'd2,
		REG_VIEW_HEIGHT = 2'd3
	} cfg_reg_t;

	// axis pipeline: compare, multiply, divider, left apply, right test,
	// multiply, divider, final apply; each divider is QW+1 = c+3 stages
	function automatic int lane_lat(input int c);
		return 2 * c + 12;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/blitclp_div.sv =====
`default_nettype none
module blitclp_div #(
	parameter int NW = 32,
	parameter int DW = 16,
	parameter int QW = 18,
	parameter int SW = 8
) (
	input  logic          clk,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic [QW-1:0] quot,
	output logic          ovf,
	output logic [SW-1:0] side_out
);

	logic [DW-1:0] rem_s  [0:QW-1];
	logic [DW-1:0] den_s  [0:QW-1];
	logic [QW-1:0] qn_s   [0:QW];
	logic          ovf_s  [0:QW];
	logic [SW-1:0] side_s [0:QW];

	// quotient fits QW bits only when the upper dividend part is below den
	always_ff @(posedge clk) begin
		rem_s[0]  <= DW'(num >> QW);
		qn_s[0]   <= num[QW-1:0];
		ovf_s[0]  <= (num >> QW) >= NW'(den);
		den_s[0]  <= den;
		side_s[0] <= side_in;
	end

	for (genvar k = 1; k <= QW; k++) begin : g_step
		logic [DW:0] shf;
		logic [DW:0] dif;
		logic        ge;

		// bring down the next dividend bit from the top of the shift word
		assign shf = {rem_s[k-1], qn_s[k-1][QW-1]};
		assign ge  = shf >= {1'b0, den_s[k-1]};
		assign dif = shf - {1'b0, den_s[k-1]};

		always_ff @(posedge clk) begin
			qn_s[k]   <= {qn_s[k-1][QW-2:0], ge};
			ovf_s[k]  <= ovf_s[k-1];
			side_s[k] <= side_s[k-1];
		end

		if (k < QW) begin : g_rem
			always_ff @(posedge clk) begin
				rem_s[k] <= ge ? dif[DW-1:0] : shf[DW-1:0];
				den_s[k] <= den_s[k-1];
			end
		end
	end

	assign quot     = qn_s[QW];
	assign ovf      = ovf_s[QW];
	assign side_out = side_s[QW];

endmodule
`default_nettype wire

// ===== hdl/blitclp_axis.sv =====
`default_nettype none
module blitclp_axis #(
	parameter int C = 16
) (
	input  logic                clk,
	input  logic signed [C-1:0] pos,
	input  logic        [C-2:0] sz,
	input  logic signed [C-1:0] tpos,
	input  logic        [C-2:0] tsz,
	input  logic signed [C-1:0] vlo,
	input  logic        [C-2:0] vext,
	output logic signed [C-1:0] clip_pos,
	output logic        [C:0]   clip_size,
	output logic        [C:0]   tex_pos,
	output logic        [C:0]   tex_size
);

	localparam int QW  = C + 2;
	localparam int NW1 = 2 * C;
	localparam int NW2 = 2 * C + 1;
	localparam int SW1 = 5 * C - 1;
	localparam int SW2 = 5 * C + 11;
	localparam logic signed [C+4:0] SAT_HI = {5'b00000, {C{1'b1}}};
	localparam logic signed [C+4:0] SAT_LO = {5'b11111, {C{1'b0}}};

	function automatic logic [C:0] sat(input logic signed [C+4:0] v);
		logic [C:0] r;
		if (v > SAT_HI)
			r = SAT_HI[C:0];
		else if (v < SAT_LO)
			r = SAT_LO[C:0];
		else
			r = v[C:0];
		return r;
	endfunction

	// stage 1: near-side test
	logic signed [C:0]   d1_w;
	logic                c1_s1;
	logic        [C-1:0] d1_s1;
	logic signed [C-1:0] pos_s1, tpos_s1;
	logic        [C-2:0] sz_s1, tsz_s1;

	assign d1_w = (C+1)'(vlo) - (C+1)'(pos);

	always_ff @(posedge clk) begin
		c1_s1   <= pos < vlo;
		d1_s1   <= (pos < vlo) ? d1_w[C-1:0] : '0;
		pos_s1  <= pos;
		sz_s1   <= sz;
		tpos_s1 <= tpos;
		tsz_s1  <= tsz;
	end

	// stage 2: delta times texture size
	logic        [2*C-2:0] n1_s2;
	logic                  c1_s2;
	logic        [C-1:0]   d1_s2;
	logic signed [C-1:0]   pos_s2, tpos_s2;
	logic        [C-2:0]   sz_s2, tsz_s2;

	always_ff @(posedge clk) begin
		n1_s2   <= {{(C-1){1'b0}}, d1_s1} * {{C{1'b0}}, tsz_s1};
		c1_s2   <= c1_s1;
		d1_s2   <= d1_s1;
		pos_s2  <= pos_s1;
		sz_s2   <= sz_s1;
		tpos_s2 <= tpos_s1;
		tsz_s2  <= tsz_s1;
	end

	// round to nearest: floor((2n + s) / 2s)
	logic [NW1-1:0] num1;
	logic [C-1:0]   den1;
	logic [SW1-1:0] side1_in, side1_out;
	logic [QW-1:0]  q1;
	logic           ovf1;

	assign num1     = {n1_s2, 1'b0} + {{(C+1){1'b0}}, sz_s2};
	assign den1     = {sz_s2, 1'b0};
	assign side1_in = {c1_s2, d1_s2, pos_s2, sz_s2, tpos_s2, tsz_s2};

	blitclp_div #(.NW(NW1), .DW(C), .QW(QW), .SW(SW1)) u_div_near (
		.clk      (clk),
		.num      (num1),
		.den      (den1),
		.side_in  (side1_in),
		.quot     (q1),
		.ovf      (ovf1),
		.side_out (side1_out)
	);

	logic                c1_d;
	logic        [C-1:0] d1_d;
	logic signed [C-1:0] pos_d, tpos_d;
	logic        [C-2:0] sz_d, tsz_d;
	logic        [QW-1:0] t1_w;

	assign {c1_d, d1_d, pos_d, sz_d, tpos_d, tsz_d} = side1_out;
	// clamp a huge shift: the outputs saturate the same way
	assign t1_w = (!c1_d || sz_d == '0) ? '0 : (ovf1 ? '1 : q1);

	// stage 3: apply near-side clip
	logic signed [C-1:0] x_s3;
	logic signed [C:0]   sw_s3;
	logic signed [C+3:0] tx_s3, tw_s3;

	always_ff @(posedge clk) begin
		x_s3  <= c1_d ? vlo : pos_d;
		sw_s3 <= $signed({2'b00, sz_d}) - $signed({1'b0, d1_d});
		tx_s3 <= (C+4)'(tpos_d) + $signed({2'b00, t1_w});
		tw_s3 <= $signed({5'b00000, tsz_d}) - $signed({2'b00, t1_w});
	end

	// stage 4: far-side test
	logic signed [C+2:0] d2_w;
	logic                c2_w;
	logic                c2_s4;
	logic        [C:0]   d2_s4;
	logic signed [C-1:0] x_s4;
	logic signed [C:0]   sw_s4;
	logic signed [C+3:0] tx_s4, tw_s4;

	assign d2_w = (C+3)'(x_s3) + (C+3)'(sw_s3) - (C+3)'(vlo) - $signed({4'b0000, vext});
	assign c2_w = !d2_w[C+2] && (d2_w != '0);

	always_ff @(posedge clk) begin
		c2_s4 <= c2_w;
		d2_s4 <= c2_w ? d2_w[C:0] : '0;
		x_s4  <= x_s3;
		sw_s4 <= sw_s3;
		tx_s4 <= tx_s3;
		tw_s4 <= tw_s3;
	end

	// stage 5: delta times remaining texture size; both are non-negative on a clip
	logic        [2*C-1:0] n2_s5;
	logic                  c2_s5;
	logic        [C:0]     d2_s5;
	logic signed [C-1:0]   x_s5;
	logic signed [C:0]     sw_s5;
	logic signed [C+3:0]   tx_s5, tw_s5;

	always_ff @(posedge clk) begin
		n2_s5 <= {{(C-1){1'b0}}, d2_s4} * {{(C+1){1'b0}}, tw_s4[C-2:0]};
		c2_s5 <= c2_s4;
		d2_s5 <= d2_s4;
		x_s5  <= x_s4;
		sw_s5 <= sw_s4;
		tx_s5 <= tx_s4;
		tw_s5 <= tw_s4;
	end

	logic [NW2-1:0] num2;
	logic [C-1:0]   den2;
	logic [SW2-1:0] side2_in, side2_out;
	logic [QW-1:0]  q2;
	logic           ovf2;

	assign num2     = {n2_s5, 1'b0} + {{(C+2){1'b0}}, sw_s5[C-2:0]};
	assign den2     = {sw_s5[C-2:0], 1'b0};
	assign side2_in = {c2_s5, d2_s5, x_s5, sw_s5, tx_s5, tw_s5};

	blitclp_div #(.NW(NW2), .DW(C), .QW(QW), .SW(SW2)) u_div_far (
		.clk      (clk),
		.num      (num2),
		.den      (den2),
		.side_in  (side2_in),
		.quot     (q2),
		.ovf      (ovf2),
		.side_out (side2_out)
	);

	logic                c2_d;
	logic        [C:0]   d2_d;
	logic signed [C-1:0] x_d;
	logic signed [C:0]   sw_d;
	logic signed [C+3:0] tx_d, tw_d;
	logic        [QW-1:0] t2_w;
	logic signed [C+2:0] sw6_w;
	logic signed [C+4:0] tw6_w;

	assign {c2_d, d2_d, x_d, sw_d, tx_d, tw_d} = side2_out;
	assign t2_w  = (!c2_d || sw_d == '0) ? '0 : (ovf2 ? '1 : q2);
	assign sw6_w = (C+3)'(sw_d) - $signed({2'b00, d2_d});
	assign tw6_w = (C+5)'(tw_d) - $signed({3'b000, t2_w});

	// stage 6: apply far-side clip and saturate
	logic signed [C-1:0] pos_s6;
	logic        [C:0]   size_s6, tpos_s6, tsize_s6;

	always_ff @(posedge clk) begin
		pos_s6   <= x_d;
		size_s6  <= sat((C+5)'(sw6_w));
		tpos_s6  <= sat((C+5)'(tx_d));
		tsize_s6 <= sat(tw6_w);
	end

	assign clip_pos  = pos_s6;
	assign clip_size = size_s6;
	assign tex_pos   = tpos_s6;
	assign tex_size  = tsize_s6;

endmodule
`default_nettype wire

// ===== hdl/blit_rect_clipper_unit.sv =====
// Channel   Handshake                   Payload
// request   start, busy (tied low)      dest_*, src_*, blend_alpha
// result    done, one cycle, no stall   clip_*, tex_*, out_alpha
// config    cfg_we, cfg_idx             cfg_data
//
// A request is taken every cycle.
// The two restoring dividers per axis, one quotient bit per stage, set the depth.
// X and Y axes run side by side in identical pipelines.
// Reset sets the viewport to 0,0,640,480 and clears the valid line.
// Results cannot be held off: done marks each result for exactly one cycle.
`default_nettype none
`include "blit_rect_clipper_unit_assert.svh"
module blit_rect_clipper_unit #(
	parameter int COORD_BITS = blitclp_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [COORD_BITS-1:0]        dest_x,
	input  logic signed [COORD_BITS-1:0]        dest_y,
	input  logic        [COORD_BITS-2:0]        dest_w,
	input  logic        [COORD_BITS-2:0]        dest_h,
	input  logic signed [COORD_BITS-1:0]        src_x,
	input  logic signed [COORD_BITS-1:0]        src_y,
	input  logic        [COORD_BITS-2:0]        src_w,
	input  logic        [COORD_BITS-2:0]        src_h,
	input  logic        [7:0]                   blend_alpha,
	input  logic                                cfg_we,
	input  logic        [blitclp_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic        [COORD_BITS-1:0]        cfg_data,
	output logic                                done,
	output logic signed [COORD_BITS-1:0]        clip_x,
	output logic signed [COORD_BITS-1:0]        clip_y,
	output logic signed [COORD_BITS:0]          clip_w,
	output logic signed [COORD_BITS:0]          clip_h,
	output logic signed [COORD_BITS:0]          tex_x,
	output logic signed [COORD_BITS:0]          tex_y,
	output logic signed [COORD_BITS:0]          tex_w,
	output logic signed [COORD_BITS:0]          tex_h,
	output logic        [7:0]                   out_alpha
);

	localparam int LAT = blitclp_pkg::lane_lat(COORD_BITS);

	logic signed [COORD_BITS-1:0] view_left_q, view_top_q;
	logic        [COORD_BITS-2:0] view_width_q, view_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_left_q   <= '0;
			view_top_q    <= '0;
			view_width_q  <= (COORD_BITS-1)'(blitclp_pkg::VIEW_WIDTH_RST);
			view_height_q <= (COORD_BITS-1)'(blitclp_pkg::VIEW_HEIGHT_RST);
		end else if (cfg_we) begin
			case (blitclp_pkg::cfg_reg_t'(cfg_idx))
				blitclp_pkg::REG_VIEW_LEFT:   view_left_q   <= cfg_data;
				blitclp_pkg::REG_VIEW_TOP:    view_top_q    <= cfg_data;
				blitclp_pkg::REG_VIEW_WIDTH:  view_width_q  <= cfg_data[COORD_BITS-2:0];
				blitclp_pkg::REG_VIEW_HEIGHT: view_height_q <= cfg_data[COORD_BITS-2:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// valid and alpha travel alongside the axis pipelines
	logic       vld_s   [0:LAT-1];
	logic [7:0] alpha_s [0:LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++)
				vld_s[i] <= 1'b0;
		end else begin
			vld_s[0] <= start && !busy;
			for (int i = 1; i < LAT; i++)
				vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		alpha_s[0] <= blend_alpha;
		for (int i = 1; i < LAT; i++)
			alpha_s[i] <= alpha_s[i-1];
	end

	blitclp_axis #(.C(COORD_BITS)) u_axis_x (
		.clk       (clk),
		.pos       (dest_x),
		.sz        (dest_w),
		.tpos      (src_x),
		.tsz       (src_w),
		.vlo       (view_left_q),
		.vext      (view_width_q),
		.clip_pos  (clip_x),
		.clip_size (clip_w),
		.tex_pos   (tex_x),
		.tex_size  (tex_w)
	);

	blitclp_axis #(.C(COORD_BITS)) u_axis_y (
		.clk       (clk),
		.pos       (dest_y),
		.sz        (dest_h),
		.tpos      (src_y),
		.tsz       (src_h),
		.vlo       (view_top_q),
		.vext      (view_height_q),
		.clip_pos  (clip_y),
		.clip_size (clip_h),
		.tex_pos   (tex_y),
		.tex_size  (tex_h)
	);

	assign done      = vld_s[LAT-1];
	assign out_alpha = alpha_s[LAT-1];

	`BRCU_ASSERT_IMP(a_done_follows_start, done, $past(start, LAT))
	`BRCU_ASSERT_IMP(a_alpha_matches, done, out_alpha == $past(blend_alpha, LAT))
	`BRCU_ASSERT_NEVER(a_tex_w_sign, done && !clip_w[COORD_BITS] && clip_w != '0 && tex_w[COORD_BITS])
	`BRCU_ASSERT_NEVER(a_tex_h_sign, done && !clip_h[COORD_BITS] && clip_h != '0 && tex_h[COORD_BITS])

endmodule
`default_nettype wire

// ===== bench/blit_rect_clipper_unit_tb.sv =====
`default_nettype none
module blit_rect_clipper_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int C = blitclp_pkg::COORD_BITS_DEF;
	localparam int LATENCY = blitclp_pkg::lane_lat(C);
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic signed [C-1:0] x, y;
		logic [C-2:0] w, h;
		logic signed [C-1:0] sx, sy;
		logic [C-2:0] sw, sh;
		logic [7:0] alpha;
	} blit_req_t;

	typedef struct packed {
		logic signed [C-1:0] x, y;
		logic signed [C:0] w, h, tx, ty, tw, th;
		logic [7:0] alpha;
	} draw_cmd_t;

	logic clk = 1'b0, arst_n = 1'b0;
	logic start = 1'b0, busy, done;
	logic cfg_we = 1'b0;
	blitclp_pkg::cfg_reg_t cfg_idx = blitclp_pkg::REG_VIEW_LEFT;
	logic [C-1:0] cfg_data = '0;
	blit_req_t req = '0;
	logic signed [C-1:0] clip_x, clip_y;
	logic signed [C:0] clip_w, clip_h, tex_x, tex_y, tex_w, tex_h;
	logic [7:0] out_alpha;

	longint view_left = 0, view_top = 0, view_width = 640, view_height = 480;
	draw_cmd_t pending_cmds[$];
	int mismatches = 0;
	int quiet_cycles = 0;
	bit quiet_mode = 1'b0;

	blit_rect_clipper_unit #(.COORD_BITS(C)) dut (
		.clk, .arst_n, .start, .busy,
		.dest_x(req.x), .dest_y(req.y), .dest_w(req.w), .dest_h(req.h),
		.src_x(req.sx), .src_y(req.sy), .src_w(req.sw), .src_h(req.sh),
		.blend_alpha(req.alpha), .cfg_we, .cfg_idx, .cfg_data, .done,
		.clip_x, .clip_y, .clip_w, .clip_h, .tex_x, .tex_y, .tex_w, .tex_h, .out_alpha
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint tex_shift(longint delta, longint tex, longint scr);
		longint n, d, q;
		n = delta * tex;
		if (scr == 0) return 0;
		if (scr < 0) begin
			n = -n;
			scr = -scr;
		end
		n = 2 * n + scr;
		d = 2 * scr;
		q = n / d;
		if (n % d != 0 && n < 0) q--;
		return q;
	endfunction

	function automatic logic signed [C:0] clamp_wide(longint v);
		longint hi, lo;
		hi = (longint'(1) << C) - 1;
		lo = -(longint'(1) << C);
		if (v > hi) v = hi;
		if (v < lo) v = lo;
		return v[C:0];
	endfunction

	function automatic draw_cmd_t clip_blit(blit_req_t r);
		longint x, y, w, h, tx, ty, tw, th, d, t;
		draw_cmd_t c;
		x = r.x; y = r.y; w = r.w; h = r.h;
		tx = r.sx; ty = r.sy; tw = r.sw; th = r.sh;
		if (x < view_left) begin
			d = view_left - x; t = tex_shift(d, tw, w);
			x = view_left; w -= d; tx += t; tw -= t;
		end
		if (x + w > view_left + view_width) begin
			d = x + w - view_left - view_width; t = tex_shift(d, tw, w);
			w -= d; tw -= t;
		end
		if (y < view_top) begin
			d = view_top - y; t = tex_shift(d, th, h);
			y = view_top; h -= d; ty += t; th -= t;
		end
		if (y + h > view_top + view_height) begin
			d = y + h - view_top - view_height; t = tex_shift(d, th, h);
			h -= d; th -= t;
		end
		c.x = x[C-1:0]; c.y = y[C-1:0];
		c.w = clamp_wide(w); c.h = clamp_wide(h);
		c.tx = clamp_wide(tx); c.ty = clamp_wide(ty);
		c.tw = clamp_wide(tw); c.th = clamp_wide(th);
		c.alpha = r.alpha;
		return c;
	endfunction

	// start stays high across back-to-back requests; random gaps and drain drop it
	task automatic send_blit(blit_req_t r);
		while (!quiet_mode && $urandom_range(99) < 20) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_cmds.push_back(clip_blit(r));
	endtask

	// hold the write for one edge; set_view drops the enable
	task automatic write_view(blitclp_pkg::cfg_reg_t idx, logic [C-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			blitclp_pkg::REG_VIEW_LEFT: view_left = longint'($signed(val));
			blitclp_pkg::REG_VIEW_TOP: view_top = longint'($signed(val));
			blitclp_pkg::REG_VIEW_WIDTH: view_width = longint'(val[C-2:0]);
			default: view_height = longint'(val[C-2:0]);
		endcase
	endtask

	task automatic drain;
		start <= 1'b0;
		while (pending_cmds.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic set_view(logic [C-1:0] l, logic [C-1:0] t, logic [C-1:0] w,
			logic [C-1:0] h);
		drain();
		write_view(blitclp_pkg::REG_VIEW_LEFT, l);
		write_view(blitclp_pkg::REG_VIEW_TOP, t);
		write_view(blitclp_pkg::REG_VIEW_WIDTH, w);
		write_view(blitclp_pkg::REG_VIEW_HEIGHT, h);
		cfg_we <= 1'b0;
	endtask

	function automatic blit_req_t rand_blit(bit near);
		blit_req_t r;
		logic [191:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		r = raw[$bits(blit_req_t)-1:0];
		if (near) begin
			r.x = C'(view_left + longint'($urandom_range(800)) - 300);
			r.y = C'(view_top + longint'($urandom_range(800)) - 300);
			r.w = (C-1)'($urandom_range(900));
			r.h = (C-1)'($urandom_range(900));
			r.sw = ($urandom_range(3) == 0) ? (C-1)'($urandom) : (C-1)'($urandom_range(512));
			r.sh = ($urandom_range(3) == 0) ? (C-1)'($urandom) : (C-1)'($urandom_range(512));
		end
		return r;
	endfunction

	task automatic test_directed;
		blit_req_t r;
		r = '{x: 10, y: 20, w: 100, h: 50, sx: 5, sy: 6, sw: 64, sh: 32, alpha: 8'h80};
		send_blit(r);
		r.x = -50; send_blit(r);
		r.x = 600; send_blit(r);
		r.x = 10; r.y = -30; send_blit(r);
		r.y = 450; send_blit(r);
		r = '{x: -100, y: -100, w: 1000, h: 1000, sx: -7, sy: 9, sw: 333, sh: 777,
			alpha: 8'hFF};
		send_blit(r);
		// zero screen size at a clipped side
		r = '{x: -10, y: -10, w: 0, h: 0, sx: 1, sy: 1, sw: 100, sh: 100, alpha: 0};
		send_blit(r);
		// oversized clip drives sizes negative
		r = '{x: -500, y: 700, w: 20, h: 30, sx: 0, sy: 0, sw: 7, sh: 9, alpha: 1};
		send_blit(r);
		// exact half rounding: 1*1/2
		r = '{x: -1, y: -1, w: 2, h: 2, sx: 0, sy: 0, sw: 1, sh: 1, alpha: 2};
		send_blit(r);
		r = '{x: 16'sh8000, y: 16'sh8000, w: 15'h7FFF, h: 15'h7FFF, sx: 16'sh8000,
			sy: 16'sh7FFF, sw: 15'h7FFF, sh: 15'h7FFF, alpha: 8'h55};
		send_blit(r);
		r = '{x: 16'sh7FFF, y: 16'sh7FFF, w: 15'h7FFF, h: 15'h7FFF, sx: 16'sh7FFF,
			sy: 16'sh8000, sw: 0, sh: 0, alpha: 8'hAA};
		send_blit(r);
		r = '0; send_blit(r);
	endtask

	task automatic test_view_extremes;
		set_view(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
		for (int i = 0; i < 40; i++) send_blit(rand_blit(i % 2 == 1));
		set_view(16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000);
		for (int i = 0; i < 40; i++) send_blit(rand_blit(i % 2 == 1));
		// width field ignores its top data bit
		set_view(16'hFFF0, 16'h0010, 16'hFFFF, 16'h8005);
		for (int i = 0; i < 40; i++) send_blit(rand_blit(i % 2 == 1));
	endtask

	task automatic test_random_views;
		for (int p = 0; p < 6; p++) begin
			set_view(C'($urandom), C'($urandom), C'($urandom_range(2000)),
				C'($urandom_range(2000)));
			quiet_mode = (p == 2);
			for (int i = 0; i < 110; i++) send_blit(rand_blit($urandom_range(4) != 0));
		end
		quiet_mode = 1'b0;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_view_extremes();
		test_random_views();
		drain();
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	always @(posedge clk) begin
		draw_cmd_t e;
		if (arst_n && done) begin
			if (pending_cmds.size() == 0) begin
				$error("draw command with nothing pending");
				mismatches++;
			end else begin
				e = pending_cmds.pop_front();
				if (clip_x !== e.x) begin $error("clip_x exp %0d got %0d", e.x, clip_x); mismatches++; end
				if (clip_y !== e.y) begin $error("clip_y exp %0d got %0d", e.y, clip_y); mismatches++; end
				if (clip_w !== e.w) begin $error("clip_w exp %0d got %0d", e.w, clip_w); mismatches++; end
				if (clip_h !== e.h) begin $error("clip_h exp %0d got %0d", e.h, clip_h); mismatches++; end
				if (tex_x !== e.tx) begin $error("tex_x exp %0d got %0d", e.tx, tex_x); mismatches++; end
				if (tex_y !== e.ty) begin $error("tex_y exp %0d got %0d", e.ty, tex_y); mismatches++; end
				if (tex_w !== e.tw) begin $error("tex_w exp %0d got %0d", e.tw, tex_w); mismatches++; end
				if (tex_h !== e.th) begin $error("tex_h exp %0d got %0d", e.th, tex_h); mismatches++; end
				if (out_alpha !== e.alpha) begin
					$error("out_alpha exp %0d got %0d", e.alpha, out_alpha);
					mismatches++;
				end
			end
		end
	end

	// count cycles without any transfer
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+hdl
hdl/blitclp_pkg.sv
hdl/blitclp_div.sv
hdl/blitclp_axis.sv
hdl/blit_rect_clipper_unit.sv
bench/blit_rect_clipper_unit_tb.sv
